FILE: sv/micro_language_tokenizer_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef MICRO_LANGUAGE_TOKENIZER_MACROS_SVH
`define MICRO_LANGUAGE_TOKENIZER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define MLT_ASSERT_NEVER(lbl, cond, msg) \
  `MLT_ASSERT(lbl, !(cond), msg)

`endif

FILE: sv/mlt_pkg.sv
// Types, codes and keyword tables for the tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package mlt_pkg;

  localparam int unsigned LEXEME_MAX_DEF = 32;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned POS_W = 7;

  // character classes
  typedef enum logic [3:0] {
    CL_LETTER = 4'd0,
    CL_DIGIT  = 4'd1,
    CL_PLUS   = 4'd2,
    CL_MINUS  = 4'd3,
    CL_LPAREN = 4'd4,
    CL_RPAREN = 4'd5,
    CL_COMMA  = 4'd6,
    CL_SEMI   = 4'd7,
    CL_COLON  = 4'd8,
    CL_EQUAL  = 4'd9,
    CL_EOT    = 4'd10,
    CL_SPACE  = 4'd11,
    CL_OTHER  = 4'd12
  } cls_e;

  // token kinds
  typedef enum logic [3:0] {
    TK_INICIO   = 4'd0,
    TK_FIN      = 4'd1,
    TK_LEER     = 4'd2,
    TK_ESCRIBIR = 4'd3,
    TK_ID       = 4'd4,
    TK_CONST    = 4'd5,
    TK_LPAREN   = 4'd6,
    TK_RPAREN   = 4'd7,
    TK_SEMI     = 4'd8,
    TK_COMMA    = 4'd9,
    TK_ASSIGN   = 4'd10,
    TK_PLUS     = 4'd11,
    TK_MINUS    = 4'd12,
    TK_END      = 4'd13,
    TK_ERROR    = 4'd14
  } tok_e;

  // scanner states
  typedef enum logic [3:0] {
    ST_START = 4'd0,
    ST_IDENT = 4'd1,
    ST_CONST = 4'd3,
    ST_COLON = 4'd11
  } st_e;

  typedef struct packed {
    tok_e             kind;
    logic [LEN_W-1:0] len;
    logic             too_long;
    logic             last;
  } token_t;

  // up to two tokens caused by one character
  typedef struct packed {
    logic [1:0] n;
    token_t     t0;
    token_t     t1;
  } scan_res_t;

  typedef struct packed {
    logic       room;
    logic [1:0] cnt;
  } obuf_stat_t;

  // reserved words, one row each, zero padded
  localparam int unsigned KW_NUM = 4;
  localparam logic [7:0] KW_CHARS [KW_NUM][8] = '{
    '{"i", "n", "i", "c", "i", "o", 8'h00, 8'h00},
    '{"f", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "e", "e", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "s", "c", "r", "i", "b", "i", "r"}
  };
  localparam logic [POS_W-1:0] KW_LEN [KW_NUM] = '{7'd6, 7'd3, 7'd4, 7'd8};

endpackage
`default_nettype wire

FILE: sv/mlt_scan.sv
// Character classifier, scan state machine and incremental keyword match.
`timescale 1ns / 1ps
`default_nettype none
module mlt_scan
  import mlt_pkg::*;
#(
  parameter int unsigned LEXEME_MAX = LEXEME_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  logic [7:0] char_i,
  input  logic      end_i,
  output scan_res_t res_o
);

  localparam int unsigned CW = $clog2(LEXEME_MAX + 1);

  typedef struct packed {
    logic emit;
    tok_e kind;
    logic [LEN_W-1:0] len;
    st_e  nxt;
    logic begin_lex;
  } start_t;

  st_e               st_q, st_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [KW_NUM-1:0] match_q, match_d;

  cls_e   cls;
  start_t sa;
  logic   pv, sv;
  token_t ptok, stok;
  tok_e   word_kind;
  logic   do_start, do_push;

  function automatic cls_e classify(logic [7:0] c, logic e);
    cls_e r;
    r = CL_OTHER;
    if (e) r = CL_EOT;
    else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) r = CL_LETTER;
    else if (c >= "0" && c <= "9") r = CL_DIGIT;
    else begin
      case (c)
        "+": r = CL_PLUS;
        "-": r = CL_MINUS;
        "(": r = CL_LPAREN;
        ")": r = CL_RPAREN;
        ",": r = CL_COMMA;
        ";": r = CL_SEMI;
        ":": r = CL_COLON;
        "=": r = CL_EQUAL;
        8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d: r = CL_SPACE;
        default: r = CL_OTHER;
      endcase
    end
    return r;
  endfunction

  // outcome of a character seen from the start state
  function automatic start_t start_f(cls_e k);
    start_t r;
    r = '{emit: 1'b1, kind: TK_ERROR, len: LEN_W'(1), nxt: ST_START, begin_lex: 1'b0};
    case (k)
      CL_LETTER: begin r.emit = 1'b0; r.nxt = ST_IDENT; r.begin_lex = 1'b1; end
      CL_DIGIT:  begin r.emit = 1'b0; r.nxt = ST_CONST; r.begin_lex = 1'b1; end
      CL_COLON:  begin r.emit = 1'b0; r.nxt = ST_COLON; r.begin_lex = 1'b1; end
      CL_PLUS:   r.kind = TK_PLUS;
      CL_MINUS:  r.kind = TK_MINUS;
      CL_LPAREN: r.kind = TK_LPAREN;
      CL_RPAREN: r.kind = TK_RPAREN;
      CL_COMMA:  r.kind = TK_COMMA;
      CL_SEMI:   r.kind = TK_SEMI;
      CL_EOT:    begin r.kind = TK_END; r.len = '0; end
      CL_SPACE:  r.emit = 1'b0;
      default:   r.kind = TK_ERROR;
    endcase
    return r;
  endfunction

  assign cls = classify(char_i, end_i);
  assign sa  = start_f(cls);

  // resolve a finished identifier against the reserved words
  always_comb begin
    word_kind = TK_ID;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (!ovf_q && match_q[k] && (POS_W'(cnt_q) == KW_LEN[k])) word_kind = tok_e'(4'(k));
    end
  end

  // next state and lexeme tracking
  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    match_d  = match_q;
    do_start = 1'b0;
    do_push  = 1'b0;
    case (st_q)
      ST_IDENT: begin
        if (cls == CL_LETTER || cls == CL_DIGIT) do_push = 1'b1;
        else begin
          st_d     = ST_START;
          do_start = (cls != CL_SPACE);
        end
      end
      ST_CONST: begin
        if (cls == CL_DIGIT) do_push = 1'b1;
        else begin
          st_d     = ST_START;
          do_start = (cls != CL_SPACE);
        end
      end
      ST_COLON: st_d = ST_START;
      default:  do_start = 1'b1;
    endcase
    if (do_start) begin
      st_d = sa.nxt;
      if (sa.begin_lex) begin
        cnt_d = CW'(1);
        ovf_d = 1'b0;
        for (int k = 0; k < KW_NUM; k++) match_d[k] = (char_i == KW_CHARS[k][0]);
      end
    end
    if (do_push) begin
      if (cnt_q < CW'(LEXEME_MAX)) begin
        cnt_d = cnt_q + CW'(1);
        for (int k = 0; k < KW_NUM; k++) begin
          match_d[k] = match_q[k] && (POS_W'(cnt_q) < KW_LEN[k])
                       && (char_i == KW_CHARS[k][3'(cnt_q)]);
        end
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // tokens caused by this character
  always_comb begin
    pv   = 1'b0;
    ptok = '{kind: TK_ERROR, len: '0, too_long: 1'b0, last: 1'b0};
    sv   = do_start && sa.emit;
    stok = '{kind: sa.kind, len: sa.len, too_long: 1'b0, last: 1'b0};
    case (st_q)
      ST_IDENT: begin
        pv   = !do_push;
        ptok = '{kind: word_kind, len: LEN_W'(cnt_q), too_long: ovf_q, last: 1'b0};
      end
      ST_CONST: begin
        pv   = !do_push;
        ptok = '{kind: TK_CONST, len: LEN_W'(cnt_q), too_long: ovf_q, last: 1'b0};
      end
      ST_COLON: begin
        pv = 1'b1;
        if (cls == CL_EQUAL) ptok.kind = TK_ASSIGN;
        ptok.len = (cls == CL_SPACE || cls == CL_EOT) ? LEN_W'(1) : LEN_W'(2);
        if (cls == CL_EOT) begin
          sv   = 1'b1;
          stok = '{kind: TK_END, len: '0, too_long: 1'b0, last: 1'b0};
        end
      end
      default: pv = 1'b0;
    endcase
  end

  // pack into the result pair, marking the last token
  always_comb begin
    res_o = '0;
    if (pv && sv) begin
      res_o.n  = 2'd2;
      res_o.t0 = ptok;
      res_o.t1 = stok;
      res_o.t1.last = 1'b1;
    end else if (pv) begin
      res_o.n  = 2'd1;
      res_o.t0 = ptok;
      res_o.t0.last = 1'b1;
    end else if (sv) begin
      res_o.n  = 2'd1;
      res_o.t0 = stok;
      res_o.t0.last = 1'b1;
    end
  end

  // advance the scan state once per accepted character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_START;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      match_q <= '0;
    end else if (adv_i) begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      match_q <= match_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/mlt_obuf.sv
// Two-entry result buffer that drains one token per cycle while ready_i is high.
`timescale 1ns / 1ps
`default_nettype none
module mlt_obuf
  import mlt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  scan_res_t  res_i,
  input  logic       ready_i,
  output logic       valid_o,
  output token_t     head_o,
  output obuf_stat_t stat_o
);

  logic [1:0] cnt_q;
  token_t     slot0_q, slot1_q;
  logic       pop;

  assign valid_o     = (cnt_q != 2'd0);
  assign head_o      = slot0_q;
  assign pop         = valid_o && ready_i;
  assign stat_o.cnt  = cnt_q;
  assign stat_o.room = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);

  // track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= res_i.n;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // load a fresh pair or shift the second token forward
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot0_q <= res_i.t0;
      slot1_q <= res_i.t1;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

endmodule
`default_nettype wire

FILE: sv/micro_language_tokenizer.sv
// Top level of the tokenizer: input register, scanner and result buffer.
//
//  channel  direction  tdata bits (low first)                 tuser / tlast
//  s_*      in         [7:0] char_code                        tuser: end_mark
//  m_*      out        [3:0] token_kind [9:4] lexeme_length   tlast: last
//                      [10] too_long, [15:11] zero
//
// One character per cycle while the result buffer has room: a character enters
// the input register, is scanned and its tokens are loaded into the result buffer.
// A character that causes two tokens holds the buffer while they drain, as the
// output drains one token per cycle while ready; that buffer sets the rate.
// Reset returns the scanner to the start state with both buffers empty.
// A stall on the output backs up through the buffer into the input register.
`timescale 1ns / 1ps
`default_nettype none
`include "micro_language_tokenizer_macros.svh"
module micro_language_tokenizer
  import mlt_pkg::*;
#(
  parameter int unsigned LEXEME_MAX = LEXEME_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] char_code
  input  logic        s_tuser_i,   // [0] end_mark
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,   // [3:0] token_kind, [9:4] lexeme_length, [10] too_long
  output logic        m_tlast_o    // last
);

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_end_q;
  logic       advance;
  scan_res_t  res;
  token_t     head;
  obuf_stat_t stat;

  assign advance    = in_valid_q && stat.room;
  assign s_tready_o = !in_valid_q || advance;

  // hold the accepted request until the scanner takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_char_q <= s_tdata_i;
      in_end_q  <= s_tuser_i;
    end
  end

  mlt_scan #(
    .LEXEME_MAX(LEXEME_MAX)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (advance),
    .char_i(in_char_q),
    .end_i (in_end_q),
    .res_o (res)
  );

  mlt_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance),
    .res_i  (res),
    .ready_i(m_tready_i),
    .valid_o(m_tvalid_o),
    .head_o (head),
    .stat_o (stat)
  );

  assign m_tdata_o = {5'd0, head.too_long, head.len, head.kind};
  assign m_tlast_o = head.last;

  `MLT_ASSERT_NEVER(a_obuf_bound, stat.cnt == 2'd3, "result buffer overfilled")
  `MLT_ASSERT(a_pair_follows, m_tvalid_o && m_tready_i && !m_tlast_o |=> m_tvalid_o, "second token missing")
  `MLT_ASSERT(a_in_hold, in_valid_q && !advance |=> in_valid_q && $stable(in_char_q), "input request lost")
  `MLT_ASSERT_NEVER(a_two_tail, advance && res.n == 2'd2 && res.t0.last, "first of two tokens marked last")

endmodule
`default_nettype wire
